/* src/aclp_pkg.sv */
package aclp_pkg;

   localparam int GAS_W   = 12;
   localparam int SCORE_W = 8;
   localparam int HUM_W   = 10;
   localparam int TEMP_W  = 12;
   localparam int LEVEL_W = 3;
   localparam int DRIVE_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;

   localparam logic [GAS_W-1:0] GAS_HIGH_ON  = 12'd2000;
   localparam logic [GAS_W-1:0] GAS_HIGH_OFF = 12'd1800;
   localparam logic [GAS_W-1:0] GAS_MID_ON   = 12'd1000;
   localparam logic [GAS_W-1:0] GAS_MID_OFF  = 12'd900;
   localparam logic signed [TEMP_W-1:0] TEMP_HOT_ON  = 12'sd300;
   localparam logic signed [TEMP_W-1:0] TEMP_HOT_OFF = 12'sd290;
   localparam logic [HUM_W-1:0] HUM_DRY_ON      = 10'd400;
   localparam logic [HUM_W-1:0] HUM_DRY_OFF     = 10'd450;
   localparam logic [HUM_W-1:0] HUM_ECO_DRY     = 10'd350;
   localparam logic [SCORE_W-1:0] SCORE_ECO_BAD  = 8'd40;
   localparam logic [SCORE_W-1:0] SCORE_ECO_POOR = 8'd65;

   localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 2'd0;
   localparam logic [DRIVE_W-1:0] DRIVE_LOW  = 2'd1;
   localparam logic [DRIVE_W-1:0] DRIVE_MID  = 2'd2;
   localparam logic [DRIVE_W-1:0] DRIVE_HIGH = 2'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_POLICY_MODE    = 3'd0,
      CSR_RULE_ENABLE    = 3'd1,
      CSR_SCORE_BELOW    = 3'd2,
      CSR_HUMIDITY_BELOW = 3'd3,
      CSR_TEMP_ABOVE     = 3'd4,
      CSR_PURIFIER_TGT   = 3'd5,
      CSR_FRESH_TGT      = 3'd6,
      CSR_HUMIDIFIER_TGT = 3'd7
   } csr_index_type;

   typedef enum logic {
      POLICY_AUTO = 1'b0,
      POLICY_ECO  = 1'b1
   } policy_type;

   typedef struct packed {
      policy_type                 policy_mode;
      logic                       rule_enable;
      logic [SCORE_W-1:0]         rule_score_below;
      logic [HUM_W-1:0]           rule_humidity_below;
      logic signed [TEMP_W-1:0]   rule_temp_above;
      logic [DRIVE_W-1:0]         rule_purifier_target;
      logic [DRIVE_W-1:0]         rule_fresh_target;
      logic [DRIVE_W-1:0]         rule_humidifier_target;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      policy_mode:            POLICY_AUTO,
      rule_enable:            1'b0,
      rule_score_below:       8'd50,
      rule_humidity_below:    10'd400,
      rule_temp_above:        12'sd300,
      rule_purifier_target:   DRIVE_OFF,
      rule_fresh_target:      DRIVE_OFF,
      rule_humidifier_target: DRIVE_OFF
   };

   typedef struct packed {
      logic [LEVEL_W-1:0]       now_humidifier;
      logic [LEVEL_W-1:0]       now_fresh;
      logic [LEVEL_W-1:0]       now_purifier;
      logic [2:0]               override_mask;
      logic                     is_occupied;
      logic                     occupancy_valid;
      logic signed [TEMP_W-1:0] temp_tenths;
      logic [HUM_W-1:0]         humidity_tenths;
      logic [SCORE_W-1:0]       quality_score;
      logic [GAS_W-1:0]         gas_raw;
   } req_item_type;

   typedef struct packed {
      logic               vacancy_shutdown;
      logic               rule_fired;
      logic [DRIVE_W-1:0] humidifier_out;
      logic [DRIVE_W-1:0] fresh_out;
      logic [DRIVE_W-1:0] purifier_out;
   } rsp_item_type;

   function automatic logic [DRIVE_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
      return (lvl > LEVEL_W'(DRIVE_HIGH)) ? DRIVE_HIGH : lvl[DRIVE_W-1:0];
   endfunction

   function automatic logic [DRIVE_W-1:0] max_level(input logic [DRIVE_W-1:0] a,
                                                    input logic [DRIVE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* src/air_comfort_level_policy_core.sv */
// channel | ports       | tdata (low bit up)                                       | tuser
// request | req_*  in   | gas_raw, quality_score, humidity_tenths, temp_tenths,    | present_mask
//         |             | occupancy_valid, is_occupied, override_mask,             |
//         |             | now_purifier, now_fresh, now_humidifier                  |
// result  | rsp_*  out  | purifier_out, fresh_out, humidifier_out, rule_fired,     | -
//         |             | vacancy_shutdown                                         |
// config  | csr_*  in   | register index and write data, no read-back              | -
//
// one request per cycle sustained while the result side is not stalled; a request passes
// through the request register, then the policy logic, then the result register
// synchronous active-high reset clears valids and loads register defaults
// a stalled result holds; a request is still taken while the request stage can drain
module air_comfort_level_policy_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // gas_raw, quality_score, humidity_tenths, temp_tenths, occupancy_valid, is_occupied,
   // override_mask, now_purifier, now_fresh, now_humidifier
   input  logic [aclp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // present_mask
   input  logic [aclp_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // purifier_out, fresh_out, humidifier_out, rule_fired, vacancy_shutdown
   output logic [aclp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [aclp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [aclp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import aclp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic in_v_ff, in_v_in;
   req_item_type in_item_ff, in_item_in;
   logic [REQ_USER_W-1:0] in_present_ff, in_present_in;
   logic out_v_ff, out_v_in;
   rsp_item_type out_item_ff, out_item_in;
   logic in_move;
   logic out_free;

   assign out_free   = !out_v_ff || rsp_tready;
   assign in_move    = in_v_ff && out_free;
   assign req_tready = !in_v_ff || out_free;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_item_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_POLICY_MODE:    cfg_in.policy_mode = policy_type'(csr_wdata[0]);
            CSR_RULE_ENABLE:    cfg_in.rule_enable = csr_wdata[0];
            CSR_SCORE_BELOW:    cfg_in.rule_score_below = csr_wdata[SCORE_W-1:0];
            CSR_HUMIDITY_BELOW: cfg_in.rule_humidity_below = csr_wdata[HUM_W-1:0];
            CSR_TEMP_ABOVE:     cfg_in.rule_temp_above = signed'(csr_wdata[TEMP_W-1:0]);
            CSR_PURIFIER_TGT:   cfg_in.rule_purifier_target = csr_wdata[DRIVE_W-1:0];
            CSR_FRESH_TGT:      cfg_in.rule_fresh_target = csr_wdata[DRIVE_W-1:0];
            CSR_HUMIDIFIER_TGT: cfg_in.rule_humidifier_target = csr_wdata[DRIVE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_v_in       = in_v_ff;
      in_item_in    = in_item_ff;
      in_present_in = in_present_ff;
      if (req_tvalid && req_tready) begin
         in_v_in       = 1'b1;
         in_item_in    = req_item_type'(req_tdata);
         in_present_in = req_tuser;
      end else if (in_move) begin
         in_v_in = 1'b0;
      end
   end

   // policy evaluation
   always_comb begin
      logic has_air, has_hum, has_temp;
      logic ovr_p, ovr_f, ovr_h;
      logic [GAS_W-1:0] gas;
      logic signed [TEMP_W-1:0] temp;
      logic [HUM_W-1:0] hum;
      logic [SCORE_W-1:0] score;
      logic [DRIVE_W-1:0] p, f, h;
      logic fired, vacant;
      logic air_rule, hum_rule, temp_rule;

      has_air  = in_present_ff[0];
      has_hum  = in_present_ff[1];
      has_temp = in_present_ff[2];
      ovr_p    = in_item_ff.override_mask[0];
      ovr_f    = in_item_ff.override_mask[1];
      ovr_h    = in_item_ff.override_mask[2];
      gas      = in_item_ff.gas_raw;
      temp     = in_item_ff.temp_tenths;
      hum      = in_item_ff.humidity_tenths;
      score    = in_item_ff.quality_score;
      p        = DRIVE_OFF;
      f        = DRIVE_OFF;
      h        = DRIVE_OFF;
      fired    = 1'b0;
      vacant   = 1'b0;
      air_rule  = cfg_ff.rule_enable && has_air && (score < cfg_ff.rule_score_below);
      hum_rule  = cfg_ff.rule_enable && has_hum && (hum < cfg_ff.rule_humidity_below);
      temp_rule = cfg_ff.rule_enable && has_temp && (temp > cfg_ff.rule_temp_above);

      if (in_item_ff.occupancy_valid && !in_item_ff.is_occupied) begin
         vacant = 1'b1;
      end else if (cfg_ff.policy_mode == POLICY_AUTO) begin
         if (has_air) begin
            if (gas >= GAS_HIGH_ON) begin
               p = DRIVE_HIGH;
            end else if (in_item_ff.now_purifier >= LEVEL_W'(DRIVE_HIGH) &&
                         gas >= GAS_HIGH_OFF) begin
               p = DRIVE_HIGH;
            end else if (gas >= GAS_MID_ON) begin
               p = DRIVE_MID;
            end else if (in_item_ff.now_purifier >= LEVEL_W'(DRIVE_MID) &&
                         gas >= GAS_MID_OFF) begin
               p = DRIVE_MID;
            end
         end
         if ((has_air && gas >= GAS_HIGH_ON) || (has_temp && temp > TEMP_HOT_ON)) begin
            f = DRIVE_MID;
         end else if (in_item_ff.now_fresh != '0 &&
                      ((has_air && gas >= GAS_MID_OFF) ||
                       (has_temp && temp > TEMP_HOT_OFF))) begin
            f = DRIVE_LOW;
         end
         if (has_hum) begin
            if (hum < HUM_DRY_ON) begin
               h = DRIVE_MID;
            end else if (in_item_ff.now_humidifier != '0 && hum < HUM_DRY_OFF) begin
               h = DRIVE_LOW;
            end
         end
         fired = air_rule || hum_rule || temp_rule;
         if (air_rule) begin
            p = max_level(p, cfg_ff.rule_purifier_target);
         end
         if (air_rule || temp_rule) begin
            f = max_level(f, cfg_ff.rule_fresh_target);
         end
         if (hum_rule) begin
            h = max_level(h, cfg_ff.rule_humidifier_target);
         end
      end else begin
         if (has_air) begin
            if (gas >= GAS_HIGH_ON || score < SCORE_ECO_BAD) begin
               p = DRIVE_MID;
               f = DRIVE_LOW;
            end else if (gas >= GAS_MID_ON || score < SCORE_ECO_POOR) begin
               p = DRIVE_LOW;
            end
         end
         if (has_hum && hum < HUM_ECO_DRY) begin
            h = DRIVE_LOW;
         end
         if (has_temp && temp > TEMP_HOT_ON) begin
            f = DRIVE_LOW;
         end
      end

      if (!vacant) begin
         if (ovr_p) p = clamp_level(in_item_ff.now_purifier);
         if (ovr_f) f = clamp_level(in_item_ff.now_fresh);
         if (ovr_h) h = clamp_level(in_item_ff.now_humidifier);
      end

      out_item_in = out_item_ff;
      if (in_move) begin
         out_item_in.purifier_out     = p;
         out_item_in.fresh_out        = f;
         out_item_in.humidifier_out   = h;
         out_item_in.rule_fired       = fired;
         out_item_in.vacancy_shutdown = vacant;
      end
   end

   always_comb begin
      out_v_in = out_v_ff;
      if (in_move) begin
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff    <= in_item_in;
      in_present_ff <= in_present_in;
      out_item_ff   <= out_item_in;
   end

   a_vacancy_all_off: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_item_ff.vacancy_shutdown |->
         out_item_ff.purifier_out == DRIVE_OFF && out_item_ff.fresh_out == DRIVE_OFF &&
         out_item_ff.humidifier_out == DRIVE_OFF && !out_item_ff.rule_fired)
      else $error("vacancy result with a nonzero level or rule flag");

   a_no_rule_in_eco: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cfg_ff.policy_mode == POLICY_ECO |-> !out_item_ff.rule_fired)
      else $error("rule flag set in eco mode");

   a_no_rule_disabled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !cfg_ff.rule_enable |-> !out_item_ff.rule_fired)
      else $error("rule flag set with the rule disabled");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      in_move |=> out_v_ff)
      else $error("request left the input stage without a result");

endmodule

/* dv/air_comfort_level_policy_core_tb.sv */
module air_comfort_level_policy_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aclp_pkg::*;

   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 190;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int HOLD_CYCLES      = 300;
   localparam int PRINT_CAP        = 100;

   // policy thresholds, tenths of a unit where it applies
   localparam int LIM_GAS_HIGH      = 2000;
   localparam int LIM_GAS_HIGH_KEEP = 1800;
   localparam int LIM_GAS_MID       = 1000;
   localparam int LIM_GAS_MID_KEEP  = 900;
   localparam int LIM_WARM          = 300;
   localparam int LIM_WARM_KEEP     = 290;
   localparam int LIM_DRY           = 400;
   localparam int LIM_DRY_KEEP      = 450;
   localparam int LIM_ECO_DRY       = 350;
   localparam int LIM_ECO_BAD       = 40;
   localparam int LIM_ECO_POOR      = 65;
   localparam int TOP_LEVEL         = 3;

   typedef struct packed {
      logic [2:0]   present;
      req_item_type body;
   } sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sample_type   pending_q[$];
   rsp_item_type expected_levels_q[$];
   cfg_type      live_cfg;

   int           error_count = 0;
   int           cycle_count = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   bit           send_pause = 1'b0;
   bit           hold_ask = 1'b0;
   bit           calm = 1'b0;
   bit           drive_now;
   sample_type   next_sample;
   rsp_item_type seen_levels;
   rsp_item_type due_levels;

   air_comfort_level_policy_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int clamp_to_top(int lvl);
      return (lvl > TOP_LEVEL) ? TOP_LEVEL : lvl;
   endfunction

   function automatic rsp_item_type predict_levels(req_item_type r, logic [2:0] present,
                                                   cfg_type c);
      rsp_item_type o;
      int           p, f, h, fired;
      int           gas, score, hum, temp, np, nf, nh;
      bit           has_air, has_hum, has_temp, ovr_p, ovr_f, ovr_h;
      o = '0;
      p = 0;
      f = 0;
      h = 0;
      fired = 0;
      gas = r.gas_raw;
      score = r.quality_score;
      hum = r.humidity_tenths;
      temp = $signed(r.temp_tenths);
      np = r.now_purifier;
      nf = r.now_fresh;
      nh = r.now_humidifier;
      has_air = present[0];
      has_hum = present[1];
      has_temp = present[2];
      ovr_p = r.override_mask[0];
      ovr_f = r.override_mask[1];
      ovr_h = r.override_mask[2];
      if (r.occupancy_valid && !r.is_occupied) begin
         o.vacancy_shutdown = 1'b1;
         return o;
      end
      if (c.policy_mode == POLICY_AUTO) begin
         if (has_air) begin
            if (gas >= LIM_GAS_HIGH) p = 3;
            else if (np >= 3 && gas >= LIM_GAS_HIGH_KEEP) p = 3;
            else if (gas >= LIM_GAS_MID) p = 2;
            else if (np >= 2 && gas >= LIM_GAS_MID_KEEP) p = 2;
         end
         if ((has_air && gas >= LIM_GAS_HIGH) || (has_temp && temp > LIM_WARM)) begin
            f = 2;
         end else if (nf > 0 && ((has_air && gas >= LIM_GAS_MID_KEEP) ||
                                 (has_temp && temp > LIM_WARM_KEEP))) begin
            f = 1;
         end
         if (has_hum) begin
            if (hum < LIM_DRY) h = 2;
            else if (nh > 0 && hum < LIM_DRY_KEEP) h = 1;
         end
      end else begin
         if (has_air) begin
            if (gas >= LIM_GAS_HIGH || score < LIM_ECO_BAD) begin
               p = 2;
               f = 1;
            end else if (gas >= LIM_GAS_MID || score < LIM_ECO_POOR) begin
               p = 1;
            end
         end
         if (has_hum && hum < LIM_ECO_DRY) h = 1;
         if (has_temp && temp > LIM_WARM && f < 1) f = 1;
      end
      if (ovr_p) p = clamp_to_top(np);
      if (ovr_f) f = clamp_to_top(nf);
      if (ovr_h) h = clamp_to_top(nh);
      if (c.policy_mode == POLICY_AUTO && c.rule_enable) begin
         if (has_air && score < int'(c.rule_score_below)) begin
            fired = 1;
            if (!ovr_p && p < c.rule_purifier_target) p = c.rule_purifier_target;
            if (!ovr_f && f < c.rule_fresh_target) f = c.rule_fresh_target;
         end
         if (has_hum && hum < int'(c.rule_humidity_below)) begin
            fired = 1;
            if (!ovr_h && h < c.rule_humidifier_target) h = c.rule_humidifier_target;
         end
         if (has_temp && temp > int'($signed(c.rule_temp_above))) begin
            fired = 1;
            if (!ovr_f && f < c.rule_fresh_target) f = c.rule_fresh_target;
         end
      end
      o.purifier_out = DRIVE_W'(p);
      o.fresh_out = DRIVE_W'(f);
      o.humidifier_out = DRIVE_W'(h);
      o.rule_fired = fired[0];
      return o;
   endfunction

   function automatic cfg_type make_cfg(policy_type mode, bit en, int score, int hum, int temp,
                                        int pt, int ft, int ht);
      cfg_type c;
      c.policy_mode = mode;
      c.rule_enable = en;
      c.rule_score_below = SCORE_W'(score);
      c.rule_humidity_below = HUM_W'(hum);
      c.rule_temp_above = TEMP_W'(temp);
      c.rule_purifier_target = DRIVE_W'(pt);
      c.rule_fresh_target = DRIVE_W'(ft);
      c.rule_humidifier_target = DRIVE_W'(ht);
      return c;
   endfunction

   function automatic cfg_type phase_cfg(int ph);
      case (ph)
         0: return make_cfg(POLICY_AUTO, 1'b0, 50, 400, 300, 0, 0, 0);
         1: return make_cfg(POLICY_AUTO, 1'b1, 50, 400, 300, 3, 2, 1);
         2: return make_cfg(POLICY_ECO, 1'b1, 50, 400, 300, 3, 3, 3);
         3: return make_cfg(POLICY_AUTO, 1'b1, 255, 1000, -400, 1, 2, 3);
         4: return make_cfg(POLICY_AUTO, 1'b1, 0, 0, 1250, 3, 3, 3);
         6: return make_cfg(POLICY_ECO, 1'b0, 128, 511, -1, 2, 1, 2);
         default: return make_cfg(POLICY_AUTO, 1'b1, $urandom_range(0, 255),
                                  $urandom_range(0, 1000), int'($urandom_range(0, 1650)) - 400,
                                  $urandom_range(0, 3), $urandom_range(0, 3),
                                  $urandom_range(0, 3));
      endcase
   endfunction

   function automatic sample_type make_sample(int present, int gas, int score, int hum, int temp,
                                              bit occ_valid, bit occupied, int ovr,
                                              int np, int nf, int nh);
      sample_type s;
      s.present = 3'(present);
      s.body.gas_raw = GAS_W'(gas);
      s.body.quality_score = SCORE_W'(score);
      s.body.humidity_tenths = HUM_W'(hum);
      s.body.temp_tenths = TEMP_W'(temp);
      s.body.occupancy_valid = occ_valid;
      s.body.is_occupied = occupied;
      s.body.override_mask = 3'(ovr);
      s.body.now_purifier = LEVEL_W'(np);
      s.body.now_fresh = LEVEL_W'(nf);
      s.body.now_humidifier = LEVEL_W'(nh);
      return s;
   endfunction

   function automatic int near(int base);
      return base + int'($urandom_range(0, 6)) - 3;
   endfunction

   function automatic sample_type random_sample();
      int gas, score, hum, temp;
      case ($urandom_range(0, 5))
         0: gas = near(LIM_GAS_MID_KEEP);
         1: gas = near(LIM_GAS_MID);
         2: gas = near(LIM_GAS_HIGH_KEEP);
         3: gas = near(LIM_GAS_HIGH);
         default: gas = $urandom_range(0, 4095);
      endcase
      case ($urandom_range(0, 4))
         0: score = near(LIM_ECO_BAD);
         1: score = near(LIM_ECO_POOR);
         2: score = near(live_cfg.rule_score_below);
         default: score = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 6))
         0: hum = near(LIM_ECO_DRY);
         1: hum = near(LIM_DRY);
         2: hum = near(LIM_DRY_KEEP);
         3: hum = near(live_cfg.rule_humidity_below);
         4: hum = $urandom_range(0, 1023);
         default: hum = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 5))
         0: temp = near(LIM_WARM_KEEP);
         1: temp = near(LIM_WARM);
         2: temp = near(int'($signed(live_cfg.rule_temp_above)));
         3: temp = $urandom_range(0, 4095);
         default: temp = int'($urandom_range(0, 1650)) - 400;
      endcase
      return make_sample(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 7,
                         gas, score, hum, temp, $urandom_range(0, 1),
                         $urandom_range(0, 3) != 0,
                         $urandom_range(0, 1) ? $urandom_range(0, 7) : 0,
                         $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
   endfunction

   task automatic push_directed(int ph);
      case (ph)
         0: begin
            pending_q.push_back(make_sample(7, 4095, 0, 0, 1250, 1, 0, 7, 7, 7, 7));
            pending_q.push_back(make_sample(0, 4095, 255, 1000, 1250, 0, 0, 0, 3, 3, 3));
            pending_q.push_back(make_sample(1, 2000, 100, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 1999, 100, 500, 0, 1, 1, 0, 3, 0, 0));
            pending_q.push_back(make_sample(1, 1800, 100, 500, 0, 0, 1, 0, 7, 0, 0));
            pending_q.push_back(make_sample(1, 1799, 100, 500, 0, 0, 0, 0, 2, 0, 0));
            pending_q.push_back(make_sample(1, 1000, 100, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 999, 100, 500, 0, 1, 1, 0, 2, 1, 0));
            pending_q.push_back(make_sample(1, 900, 100, 500, 0, 1, 1, 0, 2, 1, 0));
            pending_q.push_back(make_sample(1, 899, 100, 500, 0, 1, 1, 0, 2, 1, 0));
            pending_q.push_back(make_sample(1, 0, 100, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 301, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 300, 1, 1, 0, 0, 1, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 291, 1, 1, 0, 0, 4, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 290, 1, 1, 0, 0, 1, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, -400, 1, 1, 0, 0, 1, 0));
            pending_q.push_back(make_sample(2, 0, 100, 399, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(2, 0, 100, 449, 0, 1, 1, 0, 0, 0, 1));
            pending_q.push_back(make_sample(2, 0, 100, 450, 0, 1, 1, 0, 0, 0, 1));
            pending_q.push_back(make_sample(2, 0, 100, 0, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(2, 0, 100, 1023, 0, 1, 1, 0, 0, 0, 5));
            pending_q.push_back(make_sample(7, 4095, 0, 0, 1250, 1, 1, 7, 5, 4, 6));
            pending_q.push_back(make_sample(7, 0, 255, 1000, -1, 0, 1, 5, 2, 7, 1));
         end
         1: begin
            pending_q.push_back(make_sample(1, 0, 49, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 0, 50, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(2, 0, 100, 399, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 301, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(7, 0, 0, 0, 1250, 1, 1, 7, 0, 0, 0));
            pending_q.push_back(make_sample(7, 0, 0, 0, 1250, 1, 1, 3, 6, 0, 0));
            pending_q.push_back(make_sample(0, 0, 0, 0, 1250, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(7, 0, 0, 0, 1250, 1, 0, 0, 0, 0, 0));
         end
         2: begin
            pending_q.push_back(make_sample(1, 2000, 255, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 1999, 39, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 0, 40, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 0, 64, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 999, 65, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(1, 1000, 65, 500, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(2, 0, 100, 349, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(2, 0, 100, 350, 0, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 301, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(4, 0, 100, 500, 300, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(7, 4095, 0, 0, 1250, 1, 1, 0, 0, 0, 0));
            pending_q.push_back(make_sample(7, 4095, 0, 0, 1250, 0, 0, 7, 7, 6, 5));
            pending_q.push_back(make_sample(7, 4095, 0, 0, 1250, 1, 0, 7, 7, 6, 5));
         end
         default: ;
      endcase
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
   endtask

   task automatic load_config(cfg_type c);
      write_reg(CSR_POLICY_MODE, CSR_DATA_W'(c.policy_mode));
      write_reg(CSR_RULE_ENABLE, CSR_DATA_W'(c.rule_enable));
      write_reg(CSR_SCORE_BELOW, CSR_DATA_W'(c.rule_score_below));
      write_reg(CSR_HUMIDITY_BELOW, CSR_DATA_W'(c.rule_humidity_below));
      write_reg(CSR_TEMP_ABOVE, CSR_DATA_W'(c.rule_temp_above));
      write_reg(CSR_PURIFIER_TGT, CSR_DATA_W'(c.rule_purifier_target));
      write_reg(CSR_FRESH_TGT, CSR_DATA_W'(c.rule_fresh_target));
      write_reg(CSR_HUMIDIFIER_TGT, CSR_DATA_W'(c.rule_humidifier_target));
      @(posedge clock);
      csr_we <= 1'b0;
      live_cfg = c;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || expected_levels_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t ns: %s mismatch, got %0d want %0d", $realtime, what, got, want);
   endtask

   // stimulus
   initial begin
      live_cfg = make_cfg(POLICY_AUTO, 1'b0, 50, 400, 300, 0, 0, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1) calm = 1'b1;
         load_config(phase_cfg(ph));
         @(negedge clock);
         push_directed(ph);
         for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) pending_q.push_back(random_sample());
         // long receiver hold-off while requests keep coming
         if (ph == 2 || ph == 5) hold_ask = 1'b1;
         do @(negedge clock); while (pending_q.size() != 0);
         // sender pause until every result is back
         send_pause = 1'b1;
         for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) pending_q.push_back(random_sample());
         do @(negedge clock); while (req_tvalid || expected_levels_q.size() != 0);
         send_pause = 1'b0;
         wait_drained();
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("air_comfort_level_policy_core regression: pass");
      end else begin
         $display("air_comfort_level_policy_core regression: fail");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_levels_q.push_back(predict_levels(req_item_type'(req_tdata), req_tuser,
                                                       live_cfg));
         if (!(req_tvalid && !req_tready)) begin
            drive_now = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (!send_pause && pending_q.size() != 0) begin
               if (!calm && $urandom_range(0, 15) == 0) begin
                  send_gap = $urandom_range(1, 19) - 1;
               end else begin
                  next_sample = pending_q.pop_front();
                  drive_now = 1'b1;
               end
            end
            req_tvalid <= drive_now;
            if (drive_now) begin
               req_tdata <= next_sample.body;
               req_tuser <= next_sample.present;
            end
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_levels = rsp_item_type'(rsp_tdata);
         if (expected_levels_q.size() == 0) begin
            report_mismatch("unexpected result", seen_levels, 0);
         end else begin
            due_levels = expected_levels_q.pop_front();
            if (seen_levels.purifier_out !== due_levels.purifier_out)
               report_mismatch("purifier_out", seen_levels.purifier_out,
                               due_levels.purifier_out);
            if (seen_levels.fresh_out !== due_levels.fresh_out)
               report_mismatch("fresh_out", seen_levels.fresh_out, due_levels.fresh_out);
            if (seen_levels.humidifier_out !== due_levels.humidifier_out)
               report_mismatch("humidifier_out", seen_levels.humidifier_out,
                               due_levels.humidifier_out);
            if (seen_levels.rule_fired !== due_levels.rule_fired)
               report_mismatch("rule_fired", seen_levels.rule_fired, due_levels.rule_fired);
            if (seen_levels.vacancy_shutdown !== due_levels.vacancy_shutdown)
               report_mismatch("vacancy_shutdown", seen_levels.vacancy_shutdown,
                               due_levels.vacancy_shutdown);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("air_comfort_level_policy_core regression: fail");
         $finish;
      end
   end

endmodule
